// ----- rtl/dpf_pkg.sv -----
// dpf_pkg: shared types and constants for the dpd pair force pipeline
// no dependencies; imported by every rtl module of the block
package dpf_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CUTOFF = 2'd0,
        CFG_CONS   = 2'd1,
        CFG_DISS   = 2'd2,
        CFG_RAND   = 2'd3
    } t_cfg_idx;

    // fixed field widths
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 31;
    localparam int RC_W      = 20;
    localparam int GAIN_W    = 31;
    localparam int POS_W     = 20;
    localparam int VEL_W     = 24;
    localparam int NOISE_W   = 20;
    localparam int FORCE_W   = 32;

    // register reset values
    localparam logic [RC_W-1:0]   RST_CUTOFF = 20'd65536;
    localparam logic [GAIN_W-1:0] RST_CONS   = 31'd1638400;
    localparam logic [GAIN_W-1:0] RST_DISS   = 31'd294912;
    localparam logic [GAIN_W-1:0] RST_RAND   = 31'd1966080;

    // quotient bits of the projected velocity and magnitude bits of the pair force
    localparam int DOT_QW   = 26;
    localparam int FP_MAG_W = 40;

    // per-stage control shared with the pipelined units
    typedef struct packed {
        logic adv;
        logic valid;
    } t_stage_ctl;

endpackage

// ----- rtl/dpf_sqrt.sv -----
// dpf_sqrt: pipelined floor square root, one root bit per stage
// depends on dpf_pkg for the stage control struct
module dpf_sqrt #(
    parameter int XW = 42,
    parameter int RW = 21,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dpf_pkg::t_stage_ctl  i_ctl,
    input  logic [XW-1:0]        i_rad,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [RW-1:0]        o_root,
    output logic [SW-1:0]        o_side
);
    import dpf_pkg::*;

    logic          r_valid [RW];
    logic [RW-1:0] r_root  [RW];
    logic [XW-1:0] r_rem   [RW];
    logic [SW-1:0] r_side  [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stg
        localparam int B = RW - 1 - s;
        logic          w_vin;
        logic [RW-1:0] w_root_in;
        logic [XW-1:0] w_rem_in;
        logic [SW-1:0] w_side_in;
        logic [XW+1:0] w_cand;
        logic          w_take;

        // stage inputs
        if (s == 0) begin : g_first
            assign w_vin     = i_ctl.valid;
            assign w_root_in = '0;
            assign w_rem_in  = i_rad;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vin     = r_valid[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_side_in = r_side[s-1];
        end

        // (root + 2^B)^2 - root^2
        assign w_cand = ((XW+2)'(w_root_in) << (B + 1)) + ((XW+2)'(1) << (2 * B));
        assign w_take = (XW+2)'(w_rem_in) >= w_cand;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_ctl.adv) begin
                r_valid[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_side[s] <= w_side_in;
                if (w_take) begin
                    r_rem[s]  <= XW'((XW+2)'(w_rem_in) - w_cand);
                    r_root[s] <= w_root_in | (RW'(1) << B);
                end else begin
                    r_rem[s]  <= w_rem_in;
                    r_root[s] <= w_root_in;
                end
            end
        end
    end

    assign o_valid = r_valid[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// ----- rtl/dpf_div.sv -----
// dpf_div: pipelined restoring divider, one quotient bit per stage
// depends on dpf_pkg; needs num < den * 2^QW for an exact quotient
module dpf_div #(
    parameter int NW  = 46,
    parameter int DVW = 21,
    parameter int QW  = 26,
    parameter int SW  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dpf_pkg::t_stage_ctl  i_ctl,
    input  logic [NW-1:0]        i_num,
    input  logic [DVW-1:0]       i_den,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [QW-1:0]        o_quot,
    output logic [SW-1:0]        o_side
);
    import dpf_pkg::*;

    logic           r_valid [QW];
    logic [DVW-1:0] r_rem   [QW];
    logic [NW-1:0]  r_num   [QW];
    logic [DVW-1:0] r_den   [QW];
    logic [QW-1:0]  r_quot  [QW];
    logic [SW-1:0]  r_side  [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stg
        localparam int B = QW - 1 - s;
        logic           w_vin;
        logic [DVW-1:0] w_rem_in;
        logic [NW-1:0]  w_num_in;
        logic [DVW-1:0] w_den_in;
        logic [QW-1:0]  w_quot_in;
        logic [SW-1:0]  w_side_in;
        logic [DVW:0]   w_trial;
        logic           w_ge;

        // stage inputs
        if (s == 0) begin : g_first
            assign w_vin     = i_ctl.valid;
            assign w_rem_in  = DVW'(i_num >> QW);
            assign w_num_in  = i_num;
            assign w_den_in  = i_den;
            assign w_quot_in = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vin     = r_valid[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_num_in  = r_num[s-1];
            assign w_den_in  = r_den[s-1];
            assign w_quot_in = r_quot[s-1];
            assign w_side_in = r_side[s-1];
        end

        // bring down the next numerator bit and try the subtraction
        assign w_trial = {w_rem_in, w_num_in[B]};
        assign w_ge    = w_trial >= {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_ctl.adv) begin
                r_valid[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_num[s]  <= w_num_in;
                r_den[s]  <= w_den_in;
                r_side[s] <= w_side_in;
                r_rem[s]  <= w_ge ? DVW'(w_trial - {1'b0, w_den_in}) : DVW'(w_trial);
                r_quot[s] <= w_quot_in | (QW'(w_ge) << B);
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ----- rtl/dpd_pair_force_top.sv -----
// dpd_pair_force_top: pipelined dpd pair force, one particle pair per cycle unless stalled
// depends on dpf_pkg, dpf_sqrt and dpf_div
//
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_ready     positions, rel velocity, noise
//  out       output     o_out_valid / i_out_ready   force x/y/z, inside_cutoff
//  cfg       input      i_cfg_we                    i_cfg_addr, i_cfg_data
//
// one item enters per cycle; the pipeline depth comes from the bit-per-stage
// square root, three divider chains and the multiplier stages
// every stage holds while the output register is full and not taken, so a stall
// freezes the whole pipeline and o_in_ready drops with it
// synchronous active-low reset clears the valid bits and loads register defaults
module dpd_pair_force_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [dpf_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [dpf_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_i_x,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_i_y,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_i_z,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_j_x,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_j_y,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_j_z,
    input  logic signed [dpf_pkg::VEL_W-1:0]      i_rel_vel_x,
    input  logic signed [dpf_pkg::VEL_W-1:0]      i_rel_vel_y,
    input  logic signed [dpf_pkg::VEL_W-1:0]      i_rel_vel_z,
    input  logic signed [dpf_pkg::NOISE_W-1:0]    i_noise_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [dpf_pkg::FORCE_W-1:0]    o_force_x,
    output logic signed [dpf_pkg::FORCE_W-1:0]    o_force_y,
    output logic signed [dpf_pkg::FORCE_W-1:0]    o_force_z,
    output logic                                  o_inside_cutoff
);
    import dpf_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int BOX   = 10 << F;
    localparam int HALF  = 5 << F;
    localparam int BOX_W = $clog2(BOX + 1);
    localparam int WW    = ((BOX_W > POS_W) ? BOX_W : POS_W) + 2;
    localparam int MAG_W = POS_W;                 // |d| stays below 2^20 after one wrap
    localparam int DW    = MAG_W + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int R2W   = 2 * MAG_W + 2;
    localparam int RW    = MAG_W + 1;
    localparam int DVP_W = DW + VEL_W;
    localparam int DNW   = DVP_W + 2;
    localparam int DOT_W = DOT_QW + 1;
    localparam int RND_W = GAIN_W + NOISE_W + 1;
    localparam int DIS_W = GAIN_W + DOT_W + 1;
    localparam int FPS_W = DIS_W + 2;
    localparam int HW    = FP_MAG_W / 2;
    localparam int PP_W  = MAG_W + HW;
    localparam int PW    = MAG_W + FP_MAG_W;

    localparam logic signed [FPS_W-1:0] FP_POS = {{(FPS_W-FP_MAG_W){1'b0}}, {FP_MAG_W{1'b1}}};
    localparam logic signed [FPS_W-1:0] FP_NEG = -FP_POS;
    localparam logic [FP_MAG_W-1:0] Q_MAX = FP_MAG_W'(32'h7fff_ffff);
    localparam logic [FP_MAG_W-1:0] Q_MIN = FP_MAG_W'(32'h8000_0000);

    typedef struct packed {
        logic signed [2:0][DW-1:0] d;
        logic [RW-1:0]             r;
        logic                      in_cut;
        logic                      zero;
    } t_geo;

    typedef struct packed {
        logic signed [2:0][DW-1:0]   d;
        logic signed [DNW-1:0]       dn;
        logic signed [NOISE_W-1:0]   noise;
    } t_sq_side;

    typedef struct packed {
        t_geo                        geo;
        logic                        dn_neg;
        logic [DNW-2:0]              dn_mag;
        logic signed [NOISE_W-1:0]   noise;
    } t_wd_side;

    typedef struct packed {
        t_geo                        geo;
        logic                        dn_neg;
        logic signed [NOISE_W-1:0]   noise;
        logic [F-1:0]                w;
    } t_dd_side;

    // minimum image of one displacement component
    function automatic logic signed [DW-1:0] f_wrap(input logic [POS_W-1:0] a,
                                                    input logic [POS_W-1:0] b);
        logic signed [WW-1:0] v;
        v = $signed(WW'(a)) - $signed(WW'(b));
        if (v < -$signed(WW'(HALF))) begin
            v = v + $signed(WW'(BOX));
        end else if (v > $signed(WW'(HALF))) begin
            v = v - $signed(WW'(BOX));
        end
        return $signed(DW'(v));
    endfunction

    // ---------------- configuration registers
    logic [RC_W-1:0]   r_cutoff;
    logic [GAIN_W-1:0] r_cons_gain;
    logic [GAIN_W-1:0] r_diss_gain;
    logic [GAIN_W-1:0] r_rand_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff    <= RST_CUTOFF;
            r_cons_gain <= RST_CONS;
            r_diss_gain <= RST_DISS;
            r_rand_gain <= RST_RAND;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_CUTOFF: r_cutoff    <= i_cfg_data[RC_W-1:0];
                CFG_CONS:   r_cons_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_DISS:   r_diss_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_RAND:   r_rand_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance
    logic       r_out_valid;
    logic       w_adv;
    t_stage_ctl w_ctl_sq;
    t_stage_ctl w_ctl_wd;
    t_stage_ctl w_ctl_dd;
    t_stage_ctl w_ctl_fd;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // ---------------- p1: minimum image
    logic                        r_p1_valid;
    logic signed [2:0][DW-1:0]   r_p1_d;
    logic signed [2:0][VEL_W-1:0] r_p1_v;
    logic signed [NOISE_W-1:0]   r_p1_noise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_adv) begin
            r_p1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_d[0]  <= f_wrap(i_pos_i_x, i_pos_j_x);
            r_p1_d[1]  <= f_wrap(i_pos_i_y, i_pos_j_y);
            r_p1_d[2]  <= f_wrap(i_pos_i_z, i_pos_j_z);
            r_p1_v[0]  <= i_rel_vel_x;
            r_p1_v[1]  <= i_rel_vel_y;
            r_p1_v[2]  <= i_rel_vel_z;
            r_p1_noise <= i_noise_sample;
        end
    end

    // ---------------- p2: squares and velocity products
    logic                        r_p2_valid;
    logic [SQ_W-1:0]             r_p2_sq [3];
    logic signed [DVP_W-1:0]     r_p2_dv [3];
    logic signed [2:0][DW-1:0]   r_p2_d;
    logic signed [NOISE_W-1:0]   r_p2_noise;
    logic signed [2*DW-1:0]      w_p2_sq [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_p2_sq[k] = $signed(r_p1_d[k]) * $signed(r_p1_d[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (w_adv) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_p2_sq[k] <= SQ_W'(w_p2_sq[k]);
                r_p2_dv[k] <= $signed(r_p1_d[k]) * $signed(r_p1_v[k]);
            end
            r_p2_d     <= r_p1_d;
            r_p2_noise <= r_p1_noise;
        end
    end

    // ---------------- p3: squared distance and dot product sums
    logic                        r_p3_valid;
    logic [R2W-1:0]              r_p3_r2;
    t_sq_side                    r_p3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else if (w_adv) begin
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p3_r2 <= R2W'(r_p2_sq[0]) + R2W'(r_p2_sq[1]) + R2W'(r_p2_sq[2]);
            r_p3_side.dn <= DNW'(r_p2_dv[0]) + DNW'(r_p2_dv[1]) + DNW'(r_p2_dv[2]);
            r_p3_side.d     <= r_p2_d;
            r_p3_side.noise <= r_p2_noise;
        end
    end

    // ---------------- distance
    logic          w_sq_valid;
    logic [RW-1:0] w_sq_root;
    t_sq_side      w_sq_side;

    assign w_ctl_sq = '{adv: w_adv, valid: r_p3_valid};

    dpf_sqrt #(
        .XW (R2W),
        .RW (RW),
        .SW ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_sq),
        .i_rad   (r_p3_r2),
        .i_side  (r_p3_side),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // ---------------- p4: cutoff test and divider operands
    logic          r_p4_valid;
    logic [RC_W-1:0] r_p4_diff;
    t_wd_side      r_p4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_valid <= 1'b0;
        end else if (w_adv) begin
            r_p4_valid <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p4_diff             <= RC_W'(RW'(r_cutoff) - w_sq_root);
            r_p4_side.geo.d       <= w_sq_side.d;
            r_p4_side.geo.r       <= w_sq_root;
            r_p4_side.geo.in_cut  <= w_sq_root < RW'(r_cutoff);
            r_p4_side.geo.zero    <= w_sq_root == '0;
            r_p4_side.dn_neg      <= w_sq_side.dn < 0;
            r_p4_side.dn_mag      <= (DNW-1)'((w_sq_side.dn < 0) ? -w_sq_side.dn : w_sq_side.dn);
            r_p4_side.noise       <= w_sq_side.noise;
        end
    end

    // ---------------- weight w = (rc - r) / rc
    logic          w_wd_valid;
    logic [F-1:0]  w_wd_quot;
    t_wd_side      w_wd_side;
    t_dd_side      w_dd_in;

    assign w_ctl_wd = '{adv: w_adv, valid: r_p4_valid};

    dpf_div #(
        .NW  (RC_W + F),
        .DVW (RC_W),
        .QW  (F),
        .SW  ($bits(t_wd_side))
    ) u_div_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_wd),
        .i_num   ({r_p4_diff, {F{1'b0}}}),
        .i_den   (r_cutoff),
        .i_side  (r_p4_side),
        .o_valid (w_wd_valid),
        .o_quot  (w_wd_quot),
        .o_side  (w_wd_side)
    );

    // ---------------- projected velocity (d . v) / r
    logic              w_dd_valid;
    logic [DOT_QW-1:0] w_dd_quot;
    t_dd_side          w_dd_side;

    assign w_ctl_dd        = '{adv: w_adv, valid: w_wd_valid};
    assign w_dd_in.geo     = w_wd_side.geo;
    assign w_dd_in.dn_neg  = w_wd_side.dn_neg;
    assign w_dd_in.noise   = w_wd_side.noise;
    assign w_dd_in.w       = w_wd_quot;

    dpf_div #(
        .NW  (DNW - 1),
        .DVW (RW),
        .QW  (DOT_QW),
        .SW  ($bits(t_dd_side))
    ) u_div_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_dd),
        .i_num   (w_wd_side.dn_mag),
        .i_den   (w_wd_side.geo.r),
        .i_side  (w_dd_in),
        .o_valid (w_dd_valid),
        .o_quot  (w_dd_quot),
        .o_side  (w_dd_side)
    );

    // ---------------- m1: w squared and gain products
    logic                      r_m1_valid;
    t_geo                      r_m1_geo;
    logic [F-1:0]              r_m1_w2;
    logic [GAIN_W-1:0]         r_m1_cons;
    logic [GAIN_W-1:0]         r_m1_rg;
    logic signed [DOT_W-1:0]   r_m1_dot;
    logic signed [NOISE_W-1:0] r_m1_noise;
    logic [2*F-1:0]            w_m1_ww;
    logic [GAIN_W+F-1:0]       w_m1_cons;
    logic [GAIN_W+F-1:0]       w_m1_rg;
    logic signed [DOT_W-1:0]   w_m1_q;

    assign w_m1_ww   = w_dd_side.w * w_dd_side.w;
    assign w_m1_cons = r_cons_gain * w_dd_side.w;
    assign w_m1_rg   = r_rand_gain * w_dd_side.w;
    assign w_m1_q    = $signed({1'b0, w_dd_quot});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_adv) begin
            r_m1_valid <= w_dd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_geo   <= w_dd_side.geo;
            r_m1_w2    <= F'(w_m1_ww >> F);
            r_m1_cons  <= GAIN_W'(w_m1_cons >> F);
            r_m1_rg    <= GAIN_W'(w_m1_rg >> F);
            r_m1_dot   <= w_dd_side.dn_neg ? -w_m1_q : w_m1_q;
            r_m1_noise <= w_dd_side.noise;
        end
    end

    // ---------------- m2: friction weight and random term
    logic                      r_m2_valid;
    t_geo                      r_m2_geo;
    logic [GAIN_W-1:0]         r_m2_cons;
    logic [GAIN_W-1:0]         r_m2_gw2;
    logic signed [DOT_W-1:0]   r_m2_dot;
    logic signed [RND_W-1:0]   r_m2_rnd;
    logic [GAIN_W+F-1:0]       w_m2_gw2;
    logic signed [RND_W-1:0]   w_m2_rnd;

    assign w_m2_gw2 = r_diss_gain * r_m1_w2;
    assign w_m2_rnd = $signed({1'b0, r_m1_rg}) * r_m1_noise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (w_adv) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m2_geo  <= r_m1_geo;
            r_m2_cons <= r_m1_cons;
            r_m2_gw2  <= GAIN_W'(w_m2_gw2 >> F);
            r_m2_dot  <= r_m1_dot;
            r_m2_rnd  <= w_m2_rnd >>> F;
        end
    end

    // ---------------- m3: dissipative term
    logic                      r_m3_valid;
    t_geo                      r_m3_geo;
    logic [GAIN_W-1:0]         r_m3_cons;
    logic signed [RND_W-1:0]   r_m3_rnd;
    logic signed [DIS_W-1:0]   r_m3_diss;
    logic signed [DIS_W-1:0]   w_m3_diss;

    assign w_m3_diss = $signed({1'b0, r_m2_gw2}) * r_m2_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_valid <= 1'b0;
        end else if (w_adv) begin
            r_m3_valid <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m3_geo  <= r_m2_geo;
            r_m3_cons <= r_m2_cons;
            r_m3_rnd  <= r_m2_rnd;
            r_m3_diss <= w_m3_diss >>> F;
        end
    end

    // ---------------- m4: pair force sum, clamp, magnitudes
    logic                      r_m4_valid;
    t_geo                      r_m4_geo;
    logic [FP_MAG_W-1:0]       r_m4_fp_mag;
    logic                      r_m4_fp_neg;
    logic [MAG_W-1:0]          r_m4_dabs [3];
    logic signed [FPS_W-1:0]   w_m4_fp;
    logic signed [FPS_W-1:0]   w_m4_fp_neg;

    assign w_m4_fp     = $signed({1'b0, r_m3_cons}) - r_m3_diss + r_m3_rnd;
    assign w_m4_fp_neg = -w_m4_fp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m4_valid <= 1'b0;
        end else if (w_adv) begin
            r_m4_valid <= r_m3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m4_geo <= r_m3_geo;
            for (int k = 0; k < 3; k++) begin
                r_m4_dabs[k] <= MAG_W'(($signed(r_m3_geo.d[k]) < 0) ?
                                       -$signed(r_m3_geo.d[k]) : $signed(r_m3_geo.d[k]));
            end
            if (w_m4_fp > FP_POS) begin
                r_m4_fp_mag <= '1;
                r_m4_fp_neg <= 1'b0;
            end else if (w_m4_fp < FP_NEG) begin
                r_m4_fp_mag <= '1;
                r_m4_fp_neg <= 1'b1;
            end else begin
                r_m4_fp_mag <= FP_MAG_W'((w_m4_fp < 0) ? w_m4_fp_neg : w_m4_fp);
                r_m4_fp_neg <= w_m4_fp < 0;
            end
        end
    end

    // ---------------- m5: partial products |d| * |fpair|
    logic              r_m5_valid;
    logic [RW-1:0]     r_m5_r;
    logic              r_m5_inside;
    logic              r_m5_zero;
    logic [2:0]        r_m5_sign;
    logic [PP_W-1:0]   r_m5_pp_lo [3];
    logic [PP_W-1:0]   r_m5_pp_hi [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m5_valid <= 1'b0;
        end else if (w_adv) begin
            r_m5_valid <= r_m4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m5_r      <= r_m4_geo.r;
            r_m5_inside <= r_m4_geo.in_cut;
            r_m5_zero   <= r_m4_geo.zero;
            for (int k = 0; k < 3; k++) begin
                r_m5_sign[k]  <= ($signed(r_m4_geo.d[k]) < 0) ^ r_m4_fp_neg;
                r_m5_pp_lo[k] <= r_m4_dabs[k] * r_m4_fp_mag[HW-1:0];
                r_m5_pp_hi[k] <= r_m4_dabs[k] * r_m4_fp_mag[FP_MAG_W-1:HW];
            end
        end
    end

    // ---------------- m6: full products
    logic              r_m6_valid;
    logic [RW-1:0]     r_m6_r;
    logic              r_m6_inside;
    logic              r_m6_zero;
    logic [2:0]        r_m6_sign;
    logic [PW-1:0]     r_m6_prod [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m6_valid <= 1'b0;
        end else if (w_adv) begin
            r_m6_valid <= r_m5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m6_r      <= r_m5_r;
            r_m6_inside <= r_m5_inside;
            r_m6_zero   <= r_m5_zero;
            r_m6_sign   <= r_m5_sign;
            for (int k = 0; k < 3; k++) begin
                r_m6_prod[k] <= PW'(r_m5_pp_lo[k]) + (PW'(r_m5_pp_hi[k]) << HW);
            end
        end
    end

    // ---------------- force components, one divider lane per axis
    logic                w_fd_valid;
    logic [FP_MAG_W-1:0] w_fd_quot [3];
    logic [2:0]          w_fd_side_x;
    logic                w_fd_side_y;
    logic                w_fd_side_z;

    assign w_ctl_fd = '{adv: w_adv, valid: r_m6_valid};

    dpf_div #(
        .NW  (PW),
        .DVW (RW),
        .QW  (FP_MAG_W),
        .SW  (3)
    ) u_div_fx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_fd),
        .i_num   (r_m6_prod[0]),
        .i_den   (r_m6_r),
        .i_side  ({r_m6_inside, r_m6_zero, r_m6_sign[0]}),
        .o_valid (w_fd_valid),
        .o_quot  (w_fd_quot[0]),
        .o_side  (w_fd_side_x)
    );

    dpf_div #(
        .NW  (PW),
        .DVW (RW),
        .QW  (FP_MAG_W),
        .SW  (1)
    ) u_div_fy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_fd),
        .i_num   (r_m6_prod[1]),
        .i_den   (r_m6_r),
        .i_side  (r_m6_sign[1]),
        .o_valid (),
        .o_quot  (w_fd_quot[1]),
        .o_side  (w_fd_side_y)
    );

    dpf_div #(
        .NW  (PW),
        .DVW (RW),
        .QW  (FP_MAG_W),
        .SW  (1)
    ) u_div_fz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_fd),
        .i_num   (r_m6_prod[2]),
        .i_den   (r_m6_r),
        .i_side  (r_m6_sign[2]),
        .o_valid (),
        .o_quot  (w_fd_quot[2]),
        .o_side  (w_fd_side_z)
    );

    // ---------------- output register: sign, saturation, cutoff gating
    logic                       w_fd_inside;
    logic                       w_fd_zero;
    logic [2:0]                 w_fd_sign;
    logic signed [FORCE_W-1:0]  w_force [3];
    logic signed [FORCE_W-1:0]  r_force [3];
    logic                       r_inside;

    assign w_fd_inside = w_fd_side_x[2];
    assign w_fd_zero   = w_fd_side_x[1];
    assign w_fd_sign   = {w_fd_side_z, w_fd_side_y, w_fd_side_x[0]};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!w_fd_inside || w_fd_zero) begin
                w_force[k] = '0;
            end else if (w_fd_sign[k]) begin
                w_force[k] = (w_fd_quot[k] > Q_MIN) ? $signed(FORCE_W'(Q_MIN)) :
                             -$signed(FORCE_W'(w_fd_quot[k]));
            end else begin
                w_force[k] = (w_fd_quot[k] > Q_MAX) ? $signed(FORCE_W'(Q_MAX)) :
                             $signed(FORCE_W'(w_fd_quot[k]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_force  <= w_force;
            r_inside <= w_fd_inside;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_force_x       = r_force[0];
    assign o_force_y       = r_force[1];
    assign o_force_z       = r_force[2];
    assign o_inside_cutoff = r_inside;

endmodule

// ----- rtl/dpf_chk.sv -----
// dpf_chk: port-level checks for dpd_pair_force_top, attached by bind
// depends on dpf_pkg for field widths
module dpf_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [dpf_pkg::FORCE_W-1:0] o_force_x,
    input logic signed [dpf_pkg::FORCE_W-1:0] o_force_y,
    input logic signed [dpf_pkg::FORCE_W-1:0] o_force_z,
    input logic                               o_inside_cutoff
);
    import dpf_pkg::*;

    // a pair outside the cutoff carries no force
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inside_cutoff |->
            o_force_x == '0 && o_force_y == '0 && o_force_z == '0)
        else $error("force nonzero outside cutoff");

    // a held output item stalls the input side
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_force_x) && $stable(o_force_y) &&
            $stable(o_force_z) && $stable(o_inside_cutoff))
        else $error("stalled output item changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind dpd_pair_force_top dpf_chk u_dpf_chk (.*);

// ----- sim/dpd_pair_force_checker.sv -----
`timescale 1ns / 1ps
// dpd_pair_force_checker: watches the config port and both channels, predicts each pair force
// depends on dpf_pkg; instantiated beside the block by dpd_pair_force_top_tb
module dpd_pair_force_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [dpf_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [dpf_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_i_x,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_i_y,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_i_z,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_j_x,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_j_y,
    input  logic [dpf_pkg::POS_W-1:0]             i_pos_j_z,
    input  logic signed [dpf_pkg::VEL_W-1:0]      i_rel_vel_x,
    input  logic signed [dpf_pkg::VEL_W-1:0]      i_rel_vel_y,
    input  logic signed [dpf_pkg::VEL_W-1:0]      i_rel_vel_z,
    input  logic signed [dpf_pkg::NOISE_W-1:0]    i_noise_sample,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [dpf_pkg::FORCE_W-1:0]    i_force_x,
    input  logic signed [dpf_pkg::FORCE_W-1:0]    i_force_y,
    input  logic signed [dpf_pkg::FORCE_W-1:0]    i_force_z,
    input  logic                                  i_inside_cutoff,
    output int                                    o_errors,
    output int                                    o_pending,
    output int                                    o_forces_seen,
    output int                                    o_inside_seen
);
    import dpf_pkg::*;

    typedef struct {
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
        logic signed [FORCE_W-1:0] fz;
        logic                      in_cut;
    } t_pair_force;

    localparam longint FPAIR_MAX = (longint'(1) << 40) - 1;

    // shadow copy of the configuration registers
    logic [RC_W-1:0]   rc_q;
    logic [GAIN_W-1:0] a0_q;
    logic [GAIN_W-1:0] gamma_q;
    logic [GAIN_W-1:0] rgain_q;

    t_pair_force expected_forces[$];

    // minimum image displacement, wrapped once
    function automatic longint wrap_disp(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        longint d;
        longint half_box;
        half_box = longint'(5) <<< FRAC_BITS;
        d = longint'(a) - longint'(b);
        if (d < -half_box)
            d = d + 2 * half_box;
        else if (d > half_box)
            d = d - 2 * half_box;
        return d;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bit_v;
        res = 0;
        bit_v = 64'h1 << 62;
        while (bit_v > x)
            bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [FORCE_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // expected force on particle i for one pair
    function automatic t_pair_force predict_pair_force(
        logic [POS_W-1:0] pix, logic [POS_W-1:0] piy, logic [POS_W-1:0] piz,
        logic [POS_W-1:0] pjx, logic [POS_W-1:0] pjy, logic [POS_W-1:0] pjz,
        logic signed [VEL_W-1:0] vx, logic signed [VEL_W-1:0] vy,
        logic signed [VEL_W-1:0] vz, logic signed [NOISE_W-1:0] noise);
        t_pair_force f;
        longint dx, dy, dz, r, dot, diss, rnd, fpair;
        longint unsigned r2, w, w2, cons;
        dx = wrap_disp(pix, pjx);
        dy = wrap_disp(piy, pjy);
        dz = wrap_disp(piz, pjz);
        r2 = dx * dx + dy * dy + dz * dz;
        r = longint'(floor_sqrt(r2));
        f.fx = '0;
        f.fy = '0;
        f.fz = '0;
        f.in_cut = 1'b0;
        if (!(r < longint'(rc_q)))
            return f;
        f.in_cut = 1'b1;
        if (r == 0)
            return f;
        w = ((longint'(rc_q) - r) << FRAC_BITS) / longint'(rc_q);
        w2 = (w * w) >> FRAC_BITS;
        dot = (dx * longint'(vx) + dy * longint'(vy) + dz * longint'(vz)) / r;
        cons = (longint'(a0_q) * w) >> FRAC_BITS;
        diss = (longint'((longint'(gamma_q) * w2) >> FRAC_BITS) * dot) >>> FRAC_BITS;
        rnd = (longint'((longint'(rgain_q) * w) >> FRAC_BITS) * longint'(noise))
              >>> FRAC_BITS;
        fpair = longint'(cons) - diss + rnd;
        if (fpair > FPAIR_MAX)
            fpair = FPAIR_MAX;
        if (fpair < -FPAIR_MAX)
            fpair = -FPAIR_MAX;
        f.fx = clamp32((dx * fpair) / r);
        f.fy = clamp32((dy * fpair) / r);
        f.fz = clamp32((dz * fpair) / r);
        return f;
    endfunction

    assign o_pending = expected_forces.size();

    // register writes, accepted pairs and returned forces
    always @(posedge i_clk) begin
        t_pair_force exp_f;
        if (!i_rst_n) begin
            rc_q <= RST_CUTOFF;
            a0_q <= RST_CONS;
            gamma_q <= RST_DISS;
            rgain_q <= RST_RAND;
            expected_forces.delete();
            o_errors <= 0;
            o_forces_seen <= 0;
            o_inside_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_CUTOFF: rc_q <= i_cfg_data[RC_W-1:0];
                    CFG_CONS:   a0_q <= i_cfg_data[GAIN_W-1:0];
                    CFG_DISS:   gamma_q <= i_cfg_data[GAIN_W-1:0];
                    CFG_RAND:   rgain_q <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_forces.push_back(predict_pair_force(i_pos_i_x, i_pos_i_y,
                    i_pos_i_z, i_pos_j_x, i_pos_j_y, i_pos_j_z, i_rel_vel_x,
                    i_rel_vel_y, i_rel_vel_z, i_noise_sample));
            if (i_out_valid && i_out_ready) begin
                o_forces_seen <= o_forces_seen + 1;
                if (i_inside_cutoff)
                    o_inside_seen <= o_inside_seen + 1;
                if (expected_forces.size() == 0) begin
                    $display("%0t force item with nothing expected: %0d %0d %0d %0b",
                             $time, i_force_x, i_force_y, i_force_z, i_inside_cutoff);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_f = expected_forces.pop_front();
                    if (exp_f.fx !== i_force_x || exp_f.fy !== i_force_y ||
                        exp_f.fz !== i_force_z || exp_f.in_cut !== i_inside_cutoff) begin
                        $display("%0t force expected %0d %0d %0d in=%0b got %0d %0d %0d in=%0b",
                                 $time, exp_f.fx, exp_f.fy, exp_f.fz, exp_f.in_cut,
                                 i_force_x, i_force_y, i_force_z, i_inside_cutoff);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- sim/dpd_pair_force_top_tb.sv -----
`timescale 1ns / 1ps
// dpd_pair_force_top_tb: stimulus and verdict for the dpd pair force pipeline
// depends on dpf_pkg, dpd_pair_force_top and dpd_pair_force_checker
module dpd_pair_force_top_tb;
    import dpf_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int LATENCY    = 98 + FRAC_BITS;
    localparam int BOX        = 10 << FRAC_BITS;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int CYCLE_CAP  = 600000;
    localparam int RAND_ITEMS = 1400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [POS_W-1:0] i_pos_i_x = '0, i_pos_i_y = '0, i_pos_i_z = '0;
    logic [POS_W-1:0] i_pos_j_x = '0, i_pos_j_y = '0, i_pos_j_z = '0;
    logic signed [VEL_W-1:0] i_rel_vel_x = '0, i_rel_vel_y = '0, i_rel_vel_z = '0;
    logic signed [NOISE_W-1:0] i_noise_sample = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [FORCE_W-1:0] o_force_x, o_force_y, o_force_z;
    logic o_inside_cutoff;

    int errors, pending, forces_seen, inside_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles = 0;

    always #5 i_clk = ~i_clk;

    dpd_pair_force_top #(.FRAC_BITS(FRAC_BITS)) dut (.*);

    dpd_pair_force_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_pos_i_x, .i_pos_i_y, .i_pos_i_z, .i_pos_j_x, .i_pos_j_y, .i_pos_j_z,
        .i_rel_vel_x, .i_rel_vel_y, .i_rel_vel_z, .i_noise_sample,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_force_x(o_force_x), .i_force_y(o_force_y), .i_force_z(o_force_z),
        .i_inside_cutoff(o_inside_cutoff),
        .o_errors(errors), .o_pending(pending),
        .o_forces_seen(forces_seen), .o_inside_seen(inside_seen)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("dpd_pair_force_top: mismatch");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // cutoff currently loaded, taken from the last write on the port
    logic [RC_W-1:0] rc_written = RST_CUTOFF;
    always @(posedge i_clk)
        if (i_cfg_we && t_cfg_idx'(i_cfg_addr) == CFG_CUTOFF)
            rc_written <= i_cfg_data[RC_W-1:0];

    function automatic logic [RC_W-1:0] u_checker_rc();
        return rc_written;
    endfunction

    // write one register, called at a falling edge
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // hold off until every force has come back, then let the pipe empty
    task automatic drain_pipe();
        i_in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic load_gains(logic [19:0] rc, logic [30:0] a0, logic [30:0] gamma,
                              logic [30:0] rg);
        drain_pipe();
        write_reg(CFG_CUTOFF, {11'd0, rc});
        write_reg(CFG_CONS, a0);
        write_reg(CFG_DISS, gamma);
        write_reg(CFG_RAND, rg);
    endtask

    // offer one pair and wait for it to be taken; leaves valid high
    task automatic send_pair(logic [19:0] pix, logic [19:0] piy, logic [19:0] piz,
                             logic [19:0] pjx, logic [19:0] pjy, logic [19:0] pjz,
                             logic [23:0] vx, logic [23:0] vy, logic [23:0] vz,
                             logic [19:0] noise);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_pos_i_x = pix; i_pos_i_y = piy; i_pos_i_z = piz;
        i_pos_j_x = pjx; i_pos_j_y = pjy; i_pos_j_z = pjz;
        i_rel_vel_x = vx; i_rel_vel_y = vy; i_rel_vel_z = vz;
        i_noise_sample = noise;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // near pair around a random point, sometimes across the box edge, else anything
    task automatic send_random_pair(int rc);
        logic [19:0] pi[3], pj[3];
        int span, off, sel;
        span = (rc < 2) ? 4 : ((rc > BOX / 2) ? BOX / 2 : rc);
        sel = $urandom_range(99);
        for (int k = 0; k < 3; k++) begin
            if (sel < 80) begin
                pi[k] = 20'($urandom_range(BOX - 1));
                off = int'($urandom_range(2 * span)) - span;
                off = int'(pi[k]) + off;
                if (off < 0) off += BOX;
                if (off >= BOX) off -= BOX;
                pj[k] = 20'(off);
            end else begin
                pi[k] = 20'($urandom);
                pj[k] = 20'($urandom);
            end
        end
        send_pair(pi[0], pi[1], pi[2], pj[0], pj[1], pj[2],
                  24'($urandom), 24'($urandom), 24'($urandom), 20'($urandom));
    endtask

    initial begin
        int rc_now;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed pairs under reset values (cutoff 1.0)
        send_pair(0, 0, 0, 0, 0, 0, 24'h7fffff, 24'h800000, 0, 20'h7ffff);
        send_pair(ONE / 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, ONE / 4, 0, 0, 0, 0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 20'h80000);
        send_pair(0, 0, ONE / 3, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000, 20'h7ffff);
        send_pair(100, 200, 300, 0, 0, 0, 24'h7fffff, 24'h800000, 24'h7fffff, 20'h80000);
        send_pair(BOX - 1, 0, 0, 1000, 0, 0, 24'h1234, 0, 0, 20'h10000);
        send_pair(0, BOX - 1000, 0, 0, 2000, 0, 0, 24'h800000, 0, 20'hf0000);
        send_pair(BOX / 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, BOX / 2 + 1, 0, 0, 0, 0, 0, 0);
        send_pair(BOX / 2 + 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(20'hfffff, 20'hfffff, 20'hfffff, 0, 0, 0, 0, 0, 0, 20'h7ffff);
        send_pair(20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff, 20'hffffe,
                  24'h7fffff, 24'h7fffff, 24'h7fffff, 20'h80000);
        send_pair(ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(ONE - 1, 0, 0, 0, 0, 0, 24'h800000, 0, 0, 20'h7ffff);

        // extreme gains, cutoff of one box length: saturation
        load_gains(20'd655360, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        send_pair(0, 0, 0, 1, 0, 0, 24'h7fffff, 0, 0, 20'h7ffff);
        send_pair(BOX / 2, BOX / 2, BOX / 2, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000,
                  20'h80000);
        send_pair(3, 0, 0, 0, 0, 0, 24'h800000, 0, 0, 20'h80000);
        // smallest cutoff, zero gains, then zero cutoff
        load_gains(20'd1, 31'd0, 31'd0, 31'd0);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        load_gains(20'd0, 31'd1, 31'd1, 31'd1);
        send_pair(0, 0, 0, 0, 0, 0, 24'h7fffff, 0, 0, 20'h7ffff);
        send_pair(5, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // random pairs over several register settings and idling phases
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_gains(RST_CUTOFF, RST_CONS, RST_DISS, RST_RAND);
                1: load_gains(20'd655360, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
                2: load_gains(20'($urandom_range(1, 4 * ONE)), 31'($urandom),
                              31'($urandom), 31'($urandom));
                3: load_gains(20'($urandom_range(1, 64)), 31'($urandom_range(ONE * 100)),
                              31'($urandom_range(ONE * 100)), 31'($urandom_range(ONE * 100)));
                4: load_gains(20'($urandom_range(4 * ONE, 655360)),
                              31'($urandom_range(ONE * 50)),
                              31'($urandom_range(ONE * 10)), 31'($urandom_range(ONE * 50)));
                default: load_gains(20'($urandom), 31'($urandom), 31'($urandom),
                                    31'($urandom));
            endcase
            rc_now = int'(u_checker_rc());
            send_idle_pct = (phase < 2) ? 13 : ((phase < 4) ? 55 : 0);
            recv_idle_pct = (phase < 2) ? 55 : ((phase < 4) ? 13 : 0);
            for (int n = 0; n < RAND_ITEMS / 6; n++)
                send_random_pair(rc_now);
        end

        i_in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);

        $display("covered %0d pairs, %0d inside the cutoff, under ten register settings",
                 forces_seen, inside_seen);
        $display("idling phases on sender and receiver, saturating and zero-gain cases");
        if (errors == 0 && pending == 0)
            $display("dpd_pair_force_top: match");
        else
            $display("dpd_pair_force_top: mismatch");
        $finish;
    end

endmodule
